// ----- src/lmk_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmk_pkg
// Shared types and constants of the landmark de-duplication table.
// ----------------------------------------------------------------------------
package lmk_pkg;

    localparam int LMK_TABLE_DEPTH = 64;
    localparam int LMK_COORD_BITS  = 24;

    localparam int CFG_W    = 24;
    localparam int CFG_SQ_W = 2 * CFG_W;
    localparam int TOTAL_W  = 7;
    localparam int VERD_W   = 2;

    localparam logic [CFG_W-1:0] SAME_RADIUS_RST = CFG_W'(100000);
    localparam logic [CFG_W-1:0] RANGE_LIMIT_RST = CFG_W'(30000);

    typedef enum logic {
        CFG_SAME_RADIUS = 1'b0,
        CFG_RANGE_LIMIT = 1'b1
    } t_cfg_idx;

    typedef enum logic [VERD_W-1:0] {
        V_OUT_OF_RANGE = 2'd0,
        V_DUPLICATE    = 2'd1,
        V_STORED       = 2'd2,
        V_FULL         = 2'd3
    } t_verdict;

    typedef enum logic [2:0] {
        S_IDLE,
        S_GATE,
        S_GATE_WAIT,
        S_SCAN,
        S_SCAN_WAIT,
        S_EMIT
    } t_state;

    // Travels alongside each distance request through the pipeline
    typedef struct packed {
        logic scan;   // table entry against candidate (else vehicle gate)
        logic last;   // final table entry of this scan
    } t_dsq_tag;

endpackage

// ----- src/lmk_det_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmk_det_if
// Detection request channel: candidate point and vehicle position.
// ----------------------------------------------------------------------------
interface lmk_det_if #(
    parameter int COORD_BITS = lmk_pkg::LMK_COORD_BITS
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] cand_x;
    logic signed [COORD_BITS-1:0] cand_y;
    logic signed [COORD_BITS-1:0] cand_z;
    logic signed [COORD_BITS-1:0] vehicle_x;
    logic signed [COORD_BITS-1:0] vehicle_y;
    logic signed [COORD_BITS-1:0] vehicle_z;

    modport source (
        output valid, cand_x, cand_y, cand_z, vehicle_x, vehicle_y, vehicle_z,
        input  ready
    );
    modport sink (
        input  valid, cand_x, cand_y, cand_z, vehicle_x, vehicle_y, vehicle_z,
        output ready
    );
endinterface

// ----- src/lmk_res_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmk_res_if
// Result channel: verdict and landmark total per detection.
// ----------------------------------------------------------------------------
interface lmk_res_if;
    logic                         valid;
    logic                         ready;
    logic [lmk_pkg::VERD_W-1:0]   verdict;
    logic [lmk_pkg::TOTAL_W-1:0]  landmark_total;

    modport source (output valid, verdict, landmark_total, input ready);
    modport sink   (input valid, verdict, landmark_total, output ready);
endinterface

// ----- src/lmk_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmk_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lmk_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- src/lmk_dsq.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmk_dsq
// Three-stage squared-distance pipeline: magnitudes, squares, sum.
// ----------------------------------------------------------------------------
module lmk_dsq #(
    parameter int COORD_BITS = lmk_pkg::LMK_COORD_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_vld,
    input  lmk_pkg::t_dsq_tag            i_tag,
    input  logic signed [COORD_BITS-1:0] i_ax,
    input  logic signed [COORD_BITS-1:0] i_ay,
    input  logic signed [COORD_BITS-1:0] i_az,
    input  logic signed [COORD_BITS-1:0] i_bx,
    input  logic signed [COORD_BITS-1:0] i_by,
    input  logic signed [COORD_BITS-1:0] i_bz,
    output logic                         o_vld,
    output lmk_pkg::t_dsq_tag            o_tag,
    output logic [2*COORD_BITS+1:0]      o_sum
);
    import lmk_pkg::*;

    localparam int SQ_W  = 2 * COORD_BITS;
    localparam int SUM_W = SQ_W + 2;
    localparam int NSTG  = 3;

    logic signed [COORD_BITS-1:0] w_a [3];
    logic signed [COORD_BITS-1:0] w_b [3];
    logic signed [COORD_BITS:0]   w_diff [3];
    logic signed [COORD_BITS:0]   w_abs [3];
    logic [COORD_BITS-1:0]        n_mag [3];

    logic [COORD_BITS-1:0] r_mag [3];
    logic [SQ_W-1:0]       r_sq [3];
    logic [SUM_W-1:0]      r_sum;
    logic [NSTG-1:0]       r_vld;
    t_dsq_tag              r_tag [NSTG];

    assign w_a[0] = i_ax;
    assign w_a[1] = i_ay;
    assign w_a[2] = i_az;
    assign w_b[0] = i_bx;
    assign w_b[1] = i_by;
    assign w_b[2] = i_bz;

    // The difference magnitude never exceeds 2^COORD_BITS - 1
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_diff[k] = {w_a[k][COORD_BITS-1], w_a[k]} - {w_b[k][COORD_BITS-1], w_b[k]};
            w_abs[k]  = w_diff[k][COORD_BITS] ? -w_diff[k] : w_diff[k];
            n_mag[k]  = w_abs[k][COORD_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r_mag[k] <= n_mag[k];
            r_sq[k]  <= r_mag[k] * r_mag[k];
        end
        r_sum    <= SUM_W'(r_sq[0]) + SUM_W'(r_sq[1]) + SUM_W'(r_sq[2]);
        r_tag[0] <= i_tag;
        r_tag[1] <= r_tag[0];
        r_tag[2] <= r_tag[1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[NSTG-2:0], i_vld};
        end
    end

    assign o_vld = r_vld[NSTG-1];
    assign o_tag = r_tag[NSTG-1];
    assign o_sum = r_sum;
endmodule

// ----- src/landmark_dedup_table_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// landmark_dedup_table_top
// Landmark de-duplication table: range gate, table scan and append.
// ----------------------------------------------------------------------------
// Usage
//   i_det carries one detection request: a candidate point and the vehicle
//   position, both signed world millimetres. o_res returns exactly one result
//   per request: a verdict (out of range, duplicate, stored, table full) and
//   the number of stored landmarks after that request.
//   i_cfg_we/i_cfg_idx/i_cfg_data write the match radius and the range limit;
//   write them only while no request is in flight.
// Sequence
//   A request is taken only in the idle state. The vehicle gate sends the
//   vehicle position through the 3-stage distance pipeline; out of range or an
//   empty table goes straight to the emit state. Otherwise the N stored
//   landmarks are scanned, one RAM read per cycle, and the pipeline drains
//   before the emit state; the result register is loaded on leaving it, and
//   the block is then idle for the next request: one request at a time.
// Reset and stalls
//   Reset empties the table (count to zero) and restores the register
//   defaults; the RAM itself is not cleared since only entries below the
//   count are read. A stalled receiver holds the output register; the next
//   request may still be taken and runs up to its result, then waits.
// ----------------------------------------------------------------------------
module landmark_dedup_table_top #(
    parameter int TABLE_DEPTH = lmk_pkg::LMK_TABLE_DEPTH,
    parameter int COORD_BITS  = lmk_pkg::LMK_COORD_BITS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    lmk_det_if.sink                     i_det,
    lmk_res_if.source                   o_res,
    input  logic                        i_cfg_we,
    input  lmk_pkg::t_cfg_idx           i_cfg_idx,
    input  logic [lmk_pkg::CFG_W-1:0]   i_cfg_data
);
    import lmk_pkg::*;

    localparam int IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
    localparam int ENT_W  = 3 * COORD_BITS;
    localparam int SUM_W  = 2 * COORD_BITS + 2;
    localparam int CMP_W  = (SUM_W > CFG_SQ_W) ? SUM_W : CFG_SQ_W;
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);

    // ------------------------------------------------------------------
    // Configuration registers and their squares
    // ------------------------------------------------------------------
    logic [CFG_W-1:0]    r_radius;
    logic [CFG_W-1:0]    r_range;
    logic [CFG_SQ_W-1:0] r_rad_sq;
    logic [CFG_SQ_W-1:0] r_rng_sq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= SAME_RADIUS_RST;
            r_range  <= RANGE_LIMIT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SAME_RADIUS: r_radius <= i_cfg_data;
                CFG_RANGE_LIMIT: r_range  <= i_cfg_data;
            endcase
        end
    end

    // The squares are registered from the config registers; the compares come much later
    always_ff @(posedge i_clk) begin
        r_rad_sq <= r_radius * r_radius;
        r_rng_sq <= r_range * r_range;
    end

    // ------------------------------------------------------------------
    // Control and payload registers
    // ------------------------------------------------------------------
    t_state   r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic     r_dup, n_dup;
    t_verdict r_verdict, n_verdict;
    logic     r_rd_vld, r_rd_last;
    logic     r_out_vld, n_out_vld;
    t_verdict r_out_verdict, n_out_verdict;
    logic [TOTAL_W-1:0] r_out_total, n_out_total;

    logic signed [COORD_BITS-1:0] r_cx, r_cy, r_cz;
    logic signed [COORD_BITS-1:0] r_vx, r_vy, r_vz;

    // Datapath wiring
    logic              det_acc;
    logic              slot_free;
    logic              scan_last;
    logic              dup_now;
    t_verdict          new_verdict;
    logic              ram_we;
    logic [ENT_W-1:0]  ram_rdata;
    logic              dsq_in_vld;
    t_dsq_tag          dsq_in_tag;
    logic signed [COORD_BITS-1:0] dsq_ax, dsq_ay, dsq_az;
    logic              dsq_out_vld;
    t_dsq_tag          dsq_out_tag;
    logic [SUM_W-1:0]  dsq_sum;
    logic              out_of_range;
    logic              hit;

    assign det_acc   = i_det.valid && i_det.ready;
    assign slot_free = !r_out_vld || o_res.ready;
    assign scan_last = (r_state == S_SCAN) && (CNT_W'(r_idx) == r_count - CNT_W'(1));

    assign out_of_range = CMP_W'(dsq_sum) > CMP_W'(r_rng_sq);
    assign hit          = CMP_W'(dsq_sum) < CMP_W'(r_rad_sq);
    assign dup_now      = r_dup || (dsq_out_vld && dsq_out_tag.scan && hit);
    assign new_verdict  = dup_now ? V_DUPLICATE
                        : ((r_count < DEPTH_C) ? V_STORED : V_FULL);

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:      if (det_acc) n_state = S_GATE;
            S_GATE:      n_state = S_GATE_WAIT;
            S_GATE_WAIT: begin
                if (dsq_out_vld) begin
                    if (out_of_range || (r_count == '0)) begin
                        n_state = S_EMIT;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN:      if (scan_last) n_state = S_SCAN_WAIT;
            S_SCAN_WAIT: if (dsq_out_vld && dsq_out_tag.last) n_state = S_EMIT;
            S_EMIT:      if (slot_free) n_state = S_IDLE;
            default:     n_state = S_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Outputs of the sequencer
    // ------------------------------------------------------------------
    always_comb begin
        i_det.ready = (r_state == S_IDLE);
        dsq_in_vld  = (r_state == S_GATE) || r_rd_vld;
        dsq_in_tag  = '{scan: r_rd_vld, last: r_rd_last};
        ram_we      = (r_state == S_EMIT) && slot_free && (r_verdict == V_STORED);

        n_idx     = r_idx;
        n_dup     = r_dup;
        n_verdict = r_verdict;
        n_count   = r_count;
        n_out_vld     = r_out_vld;
        n_out_verdict = r_out_verdict;
        n_out_total   = r_out_total;

        // Scan bookkeeping: clear the match flag, step through the entries
        if (r_state == S_GATE) begin
            n_dup = 1'b0;
            n_idx = '0;
        end
        if (r_state == S_SCAN) begin
            n_idx = r_idx + IDX_W'(1);
        end
        if (dsq_out_vld && dsq_out_tag.scan) begin
            n_dup = dup_now;
        end

        // Settle the verdict once the gate or the last comparison is known
        if (r_state == S_GATE_WAIT && dsq_out_vld) begin
            n_verdict = out_of_range ? V_OUT_OF_RANGE : new_verdict;
        end
        if (r_state == S_SCAN_WAIT && dsq_out_vld && dsq_out_tag.last) begin
            n_verdict = new_verdict;
        end

        // Commit the append and load the result register together
        priority if (r_state == S_EMIT && slot_free) begin
            n_out_vld     = 1'b1;
            n_out_verdict = r_verdict;
            if (r_verdict == V_STORED) begin
                n_count = r_count + CNT_W'(1);
            end
            n_out_total = TOTAL_W'(n_count);
        end else if (o_res.ready) begin
            n_out_vld = 1'b0;
        end else begin
            n_out_vld = r_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_dup     <= 1'b0;
            r_rd_vld  <= 1'b0;
            r_rd_last <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_dup     <= n_dup;
            r_rd_vld  <= (r_state == S_SCAN);
            r_rd_last <= scan_last;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx         <= n_idx;
        r_verdict     <= n_verdict;
        r_out_verdict <= n_out_verdict;
        r_out_total   <= n_out_total;
        if (det_acc) begin
            r_cx <= i_det.cand_x;
            r_cy <= i_det.cand_y;
            r_cz <= i_det.cand_z;
            r_vx <= i_det.vehicle_x;
            r_vy <= i_det.vehicle_y;
            r_vz <= i_det.vehicle_z;
        end
    end

    // ------------------------------------------------------------------
    // Landmark store. Reads and the append never overlap: the append sits
    // in the emit state, after the scan of the same request has drained.
    // ------------------------------------------------------------------
    lmk_ram #(
        .WIDTH (ENT_W),
        .DEPTH (TABLE_DEPTH),
        .AW    (IDX_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_count[IDX_W-1:0]),
        .i_wdata ({r_cx, r_cy, r_cz}),
        .i_raddr (r_idx),
        .o_rdata (ram_rdata)
    );

    // Operand A: table entry during the scan, vehicle during the gate
    assign dsq_ax = r_rd_vld ? ram_rdata[3*COORD_BITS-1:2*COORD_BITS] : r_vx;
    assign dsq_ay = r_rd_vld ? ram_rdata[2*COORD_BITS-1:COORD_BITS]   : r_vy;
    assign dsq_az = r_rd_vld ? ram_rdata[COORD_BITS-1:0]              : r_vz;

    lmk_dsq #(
        .COORD_BITS (COORD_BITS)
    ) u_dsq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (dsq_in_vld),
        .i_tag   (dsq_in_tag),
        .i_ax    (dsq_ax),
        .i_ay    (dsq_ay),
        .i_az    (dsq_az),
        .i_bx    (r_cx),
        .i_by    (r_cy),
        .i_bz    (r_cz),
        .o_vld   (dsq_out_vld),
        .o_tag   (dsq_out_tag),
        .o_sum   (dsq_sum)
    );

    assign o_res.valid          = r_out_vld;
    assign o_res.verdict        = r_out_verdict;
    assign o_res.landmark_total = r_out_total;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH_C)
        else $error("landmark count beyond table depth");

    a_append_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_count < DEPTH_C))
        else $error("append into a full table");

    a_append_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("count did not advance after append");

    // Early scan results come back while later entries are still being read
    a_dsq_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dsq_out_vld |-> (r_state == S_GATE_WAIT || r_state == S_SCAN
                         || r_state == S_SCAN_WAIT))
        else $error("distance result outside a waiting state");

    a_accept_gate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        det_acc |=> (r_state == S_GATE))
        else $error("accepted request did not start the gate");
endmodule
